// ----- rtl/u8d_pkg.sv -----
package u8d_pkg;

  localparam int unsigned CpW  = 31;
  localparam int unsigned LenW = 3;

  // Length codes
  localparam logic [LenW-1:0] LEN_NONE = 3'd0;
  localparam logic [LenW-1:0] LEN_1    = 3'd1;
  localparam logic [LenW-1:0] LEN_2    = 3'd2;
  localparam logic [LenW-1:0] LEN_3    = 3'd3;
  localparam logic [LenW-1:0] LEN_4    = 3'd4;
  localparam logic [LenW-1:0] LEN_5    = 3'd5;
  localparam logic [LenW-1:0] LEN_6    = 3'd6;

  // Status codes
  localparam logic ST_OK  = 1'b0;
  localparam logic ST_ERR = 1'b1;

  localparam logic [7:0] PayloadMask = 8'h3F;

  // One input request as held in the input register
  typedef struct packed {
    logic [7:0] byte_val;
    logic       last;
  } u8d_item_t;

  // Decode outcome for one request
  typedef struct packed {
    logic             emit;
    logic [CpW-1:0]   cp;
    logic             err;
    logic [LenW-1:0]  len;
  } u8d_res_t;

  // Smallest value a sequence of the given length may legally carry
  function automatic logic [CpW-1:0] min_value(input logic [LenW-1:0] len);
    logic [CpW-1:0] v;
    case (len)
      LEN_2:   v = 31'h0000080;
      LEN_3:   v = 31'h0000800;
      LEN_4:   v = 31'h0010000;
      LEN_5:   v = 31'h0200000;
      LEN_6:   v = 31'h4000000;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/u8d_in_reg.sv -----
module u8d_in_reg
  import u8d_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  input  logic       advance,
  output logic       in_stall,
  output logic       valid,
  output u8d_item_t  item
);

  logic      valid_r;
  logic      valid_nxt;
  u8d_item_t item_r;
  logic      take;

  // Register is free when empty or when its request moves on this cycle
  assign in_stall  = valid_r && !advance;
  assign take      = in_valid && !in_stall;
  assign valid_nxt = take ? 1'b1 : (advance ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r.byte_val <= in_byte;
      item_r.last     <= in_last;
    end
  end

  assign valid = valid_r;
  assign item  = item_r;

endmodule

// ----- rtl/u8d_core.sv -----
module u8d_core
  import u8d_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  u8d_item_t item,
  input  logic      fire,
  output u8d_res_t  res
);

  logic [2:0]     rem_r, rem_nxt;
  logic [2:0]     slen_r, slen_nxt;
  logic [CpW-1:0] acc_r, acc_nxt;

  // Decode one byte against the sequence state
  always_comb begin
    logic [7:0]     b;
    logic [2:0]     lead_n;
    logic           lead_ok;
    logic [7:0]     lead_mask;
    logic [2:0]     taken;
    logic [CpW-1:0] acc_sh;
    logic [2:0]     rem_dec;

    b         = item.byte_val;
    lead_ok   = 1'b1;
    lead_n    = 3'd1;
    // count of continuation bytes from the first zero below the top two ones
    if (!b[5])      lead_n = 3'd1;
    else if (!b[4]) lead_n = 3'd2;
    else if (!b[3]) lead_n = 3'd3;
    else if (!b[2]) lead_n = 3'd4;
    else if (!b[1]) lead_n = 3'd5;
    else            lead_ok = 1'b0;
    lead_mask = PayloadMask >> lead_n;
    taken     = slen_r - rem_r + 3'd1;
    acc_sh    = {acc_r[CpW-7:0], b[5:0]};
    rem_dec   = rem_r - 3'd1;

    res      = '{emit: 1'b0, cp: '0, err: ST_OK, len: LEN_NONE};
    rem_nxt  = rem_r;
    slen_nxt = slen_r;
    acc_nxt  = acc_r;

    if (rem_r == 3'd0) begin
      if (!b[7]) begin
        res = '{emit: 1'b1, cp: {23'd0, b}, err: ST_OK, len: LEN_1};
      end else if (!b[6] || !lead_ok || item.last) begin
        // stray continuation, 0xFE/0xFF, or string ends on a lead byte
        res = '{emit: 1'b1, cp: '0, err: ST_ERR, len: LEN_1};
      end else begin
        rem_nxt  = lead_n;
        slen_nxt = lead_n + 3'd1;
        acc_nxt  = {23'd0, b & lead_mask};
      end
    end else if (!(b inside {[8'h80:8'hBF]})) begin
      // wrong byte inside a sequence: drop it and abandon
      res      = '{emit: 1'b1, cp: '0, err: ST_ERR, len: taken};
      rem_nxt  = '0;
      slen_nxt = '0;
      acc_nxt  = '0;
    end else if (rem_dec == 3'd0) begin
      // sequence complete; reject overlong forms
      if (acc_sh < min_value(slen_r)) begin
        res = '{emit: 1'b1, cp: '0, err: ST_ERR, len: slen_r};
      end else begin
        res = '{emit: 1'b1, cp: acc_sh, err: ST_OK, len: slen_r};
      end
      rem_nxt  = '0;
      slen_nxt = '0;
      acc_nxt  = '0;
    end else if (item.last) begin
      // string ends mid-sequence
      res      = '{emit: 1'b1, cp: '0, err: ST_ERR, len: taken};
      rem_nxt  = '0;
      slen_nxt = '0;
      acc_nxt  = '0;
    end else begin
      rem_nxt = rem_dec;
      acc_nxt = acc_sh;
    end
  end

  // Sequence state advances once per request that moves on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r  <= '0;
      slen_r <= '0;
      acc_r  <= '0;
    end else if (fire) begin
      rem_r  <= rem_nxt;
      slen_r <= slen_nxt;
      acc_r  <= acc_nxt;
    end
  end

endmodule

// ----- rtl/u8d_out_reg.sv -----
module u8d_out_reg
  import u8d_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            load,
  input  u8d_res_t        res,
  input  logic            out_stall,
  output logic            ready,
  output logic            out_valid,
  output logic [CpW-1:0]  out_code_point,
  output logic            out_status,
  output logic [LenW-1:0] out_seq_length
);

  logic            valid_r, valid_nxt;
  logic [CpW-1:0]  cp_r;
  logic            st_r;
  logic [LenW-1:0] len_r;

  // Can take a new result when empty or when the held one leaves now
  assign ready     = !valid_r || !out_stall;
  assign valid_nxt = load ? 1'b1 : (out_stall ? valid_r : 1'b0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cp_r  <= res.cp;
      st_r  <= res.err;
      len_r <= res.len;
    end
  end

  assign out_valid      = valid_r;
  assign out_code_point = cp_r;
  assign out_status     = st_r;
  assign out_seq_length = len_r;

endmodule

// ----- rtl/utf8_decoder.sv -----
// Channel   Ports                                              Direction
// input     in_valid, in_stall, in_byte, in_last_in_string     request in
// result    out_valid, out_stall, out_code_point, out_status,  request out
//           out_seq_length
//
// One byte per clock sustained unless a stalled result holds it up; a request
// waits in the input register, is decoded against the sequence state and its
// result, if any, lands in the result register.
// Reset (rst_n low, synchronous) empties both registers and returns to idle.
// A stalled result only holds up bytes that produce a result; bytes in the
// middle of a sequence keep flowing.
module utf8_decoder
  import u8d_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [7:0]      in_byte,
  input  logic            in_last_in_string,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [CpW-1:0]  out_code_point,
  output logic            out_status,
  output logic [LenW-1:0] out_seq_length
);

  logic      s1_valid;
  u8d_item_t s1_item;
  u8d_res_t  res;
  logic      out_ready;
  logic      advance;

  // Request moves on unless it has a result with nowhere to go
  assign advance = s1_valid && (!res.emit || out_ready);

  u8d_in_reg u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_byte  (in_byte),
    .in_last  (in_last_in_string),
    .advance  (advance),
    .in_stall (in_stall),
    .valid    (s1_valid),
    .item     (s1_item)
  );

  u8d_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .item  (s1_item),
    .fire  (advance),
    .res   (res)
  );

  u8d_out_reg u_out (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (advance && res.emit),
    .res            (res),
    .out_stall      (out_stall),
    .ready          (out_ready),
    .out_valid      (out_valid),
    .out_code_point (out_code_point),
    .out_status     (out_status),
    .out_seq_length (out_seq_length)
  );

endmodule

// ----- rtl/u8d_checker.sv -----
module u8d_checker
  import u8d_pkg::*;
(
  input logic            clk,
  input logic            rst_n,
  input logic            out_valid,
  input logic            out_stall,
  input logic [CpW-1:0]  out_code_point,
  input logic            out_status,
  input logic [LenW-1:0] out_seq_length
);

  // Held result stays put while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_code_point)
      && $stable(out_status) && $stable(out_seq_length))
    else $error("result changed while stalled");

  // Error results carry a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_ERR |-> out_code_point == '0)
    else $error("error result with nonzero code point");

  // Length always one to six
  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_seq_length != LEN_NONE && out_seq_length <= LEN_6)
    else $error("sequence length out of range");

  // A good single byte is ASCII
  a_len1_ascii: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_OK && out_seq_length == LEN_1
      |-> out_code_point < 31'h80)
    else $error("single-byte result above ASCII");

  // A good two-byte result is neither overlong nor too large
  a_len2_span: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_OK && out_seq_length == LEN_2
      |-> out_code_point >= 31'h80 && out_code_point < 31'h800)
    else $error("two-byte result out of span");

endmodule

bind utf8_decoder u8d_checker u_chk (.*);
